// ===== rtl/core/rv64de_pkg.sv =====
// shared types and constants for the rv64i decode and execute unit
// beat structs for both channels, major opcodes, funct7 codes, alu operations
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rv64de_pkg;

    // major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OPIMMW = 7'h1B;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_OPW    = 7'h3B;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    // funct7 selectors
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 codes that need names
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LD_INVALID = 3'd7;
    localparam logic [2:0] F3_JALR       = 3'd0;

    localparam logic [63:0] INSN_BYTES = 64'd4;

    typedef enum logic [3:0] {
        ALU_ADD  = 4'd0,
        ALU_SUB  = 4'd1,
        ALU_SLL  = 4'd2,
        ALU_SLT  = 4'd3,
        ALU_SLTU = 4'd4,
        ALU_XOR  = 4'd5,
        ALU_SRL  = 4'd6,
        ALU_SRA  = 4'd7,
        ALU_OR   = 4'd8,
        ALU_AND  = 4'd9
    } t_alu_op;

    typedef struct packed {
        logic [6:0]         opcode;
        logic [2:0]         funct3;
        logic [6:0]         funct7;
        logic [63:0]        rs1_value;
        logic [63:0]        rs2_value;
        logic signed [63:0] immediate;
        logic [63:0]        pc;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_value;
        logic        write_reg;
        logic        load_to_reg;
        logic        mem_read;
        logic        mem_write;
        logic [3:0]  mem_bytes;
        logic        mem_signed;
        logic [63:0] store_data;
        logic        redirect;
        logic [63:0] next_pc;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== rtl/core/rv64i_decode_execute_unit.sv =====
// rv64i decode and execute unit: input register, decode and alu, result register
// depends on rv64de_pkg for beat structs, opcodes and alu operation codes
`timescale 1ns / 1ps
`default_nettype none

// One RV64I instruction enters per beat on the input channel, with its major
// opcode, funct3, funct7, already forwarded source values, sign-extended
// immediate and pc. The unit decodes the control signals (register write,
// load, store, access size and signedness) and computes the result: alu
// value, effective address, upper immediate, pc+imm or the return address
// pc+4, plus the branch or jump decision with its target (jalr target has
// bit 0 cleared). Unrecognized encodings give an all-zero result beat.
// An accepted beat is held in the input register, decoded and executed
// from there; its result beat is offered from the result register.
// Throughput is one instruction per clock unless the result side stalls:
// the input register and the result register are separate stages, and a
// new beat is taken whenever the input register is empty or moves
// forward. i_out_stall backs up through both stages; o_in_stall rises only
// when both registers hold beats and the result side is stalled.
module rv64i_decode_execute_unit (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // instruction channel
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire rv64de_pkg::t_in_beat i_in_beat,
    // result channel
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output rv64de_pkg::t_out_beat  o_out_beat
);

    // pipeline registers
    logic                  r_in_valid;
    rv64de_pkg::t_in_beat  r_in;
    logic                  r_out_valid;
    rv64de_pkg::t_out_beat r_out;

    logic                  n_in_valid;
    logic                  n_out_valid;
    rv64de_pkg::t_out_beat n_out;

    // stage enables
    logic out_load;   // result register can take a new beat
    logic in_load;    // input register can take a new beat

    // execute stage signals
    logic [63:0]        op_a;
    logic [63:0]        op_b;
    logic [5:0]         sh64;
    logic [4:0]         sh32;
    logic [63:0]        sum;
    logic [63:0]        diff;
    logic [63:0]        pc_imm;
    logic [63:0]        addr;
    logic               lt_s;
    logic               lt_u;
    logic               is_eq;
    rv64de_pkg::t_alu_op alu_op;
    logic               alu_ok;
    logic               alu_word;
    logic [63:0]        alu_res;
    logic [31:0]        word_res;
    logic               taken;

    function automatic logic [63:0] sext32(input logic [31:0] x);
        sext32 = {{32{x[31]}}, x};
    endfunction

    // handshake: the result register frees up when empty or when drained
    assign out_load    = !r_out_valid || !i_out_stall;
    assign in_load     = !r_in_valid || out_load;
    assign o_in_stall  = !in_load;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    assign n_in_valid  = in_load ? i_in_valid : r_in_valid;
    assign n_out_valid = out_load ? r_in_valid : r_out_valid;

    // operands: register-register ops and branches use rs2, everything else the immediate
    always_comb begin
        op_a = r_in.rs1_value;
        if (r_in.opcode == rv64de_pkg::OPC_OP || r_in.opcode == rv64de_pkg::OPC_OPW
            || r_in.opcode == rv64de_pkg::OPC_BRANCH) begin
            op_b = r_in.rs2_value;
        end else begin
            op_b = r_in.immediate;
        end
    end

    assign sh64   = op_b[5:0];
    assign sh32   = op_b[4:0];
    assign sum    = op_a + op_b;
    assign diff   = op_a - op_b;
    assign pc_imm = r_in.pc + r_in.immediate;
    assign addr   = r_in.rs1_value + r_in.immediate;
    assign lt_s   = $signed(op_a) < $signed(op_b);
    assign lt_u   = op_a < op_b;
    assign is_eq  = op_a == op_b;

    // alu op decode for the four arithmetic opcode groups
    always_comb begin
        alu_op   = rv64de_pkg::ALU_ADD;
        alu_ok   = 1'b0;
        alu_word = 1'b0;
        unique case (r_in.opcode)
            rv64de_pkg::OPC_OP: begin
                if (r_in.funct7 == rv64de_pkg::F7_BASE) begin
                    alu_ok = 1'b1;
                    unique case (r_in.funct3)
                        rv64de_pkg::F3_ADD:  alu_op = rv64de_pkg::ALU_ADD;
                        rv64de_pkg::F3_SLL:  alu_op = rv64de_pkg::ALU_SLL;
                        rv64de_pkg::F3_SLT:  alu_op = rv64de_pkg::ALU_SLT;
                        rv64de_pkg::F3_SLTU: alu_op = rv64de_pkg::ALU_SLTU;
                        rv64de_pkg::F3_XOR:  alu_op = rv64de_pkg::ALU_XOR;
                        rv64de_pkg::F3_SR:   alu_op = rv64de_pkg::ALU_SRL;
                        rv64de_pkg::F3_OR:   alu_op = rv64de_pkg::ALU_OR;
                        default:             alu_op = rv64de_pkg::ALU_AND;
                    endcase
                end else if (r_in.funct7 == rv64de_pkg::F7_ALT) begin
                    if (r_in.funct3 == rv64de_pkg::F3_ADD) begin
                        alu_ok = 1'b1;
                        alu_op = rv64de_pkg::ALU_SUB;
                    end else if (r_in.funct3 == rv64de_pkg::F3_SR) begin
                        alu_ok = 1'b1;
                        alu_op = rv64de_pkg::ALU_SRA;
                    end
                end
            end
            rv64de_pkg::OPC_OPW: begin
                alu_word = 1'b1;
                if (r_in.funct7 == rv64de_pkg::F7_BASE) begin
                    unique case (r_in.funct3)
                        rv64de_pkg::F3_ADD: begin
                            alu_ok = 1'b1;
                            alu_op = rv64de_pkg::ALU_ADD;
                        end
                        rv64de_pkg::F3_SLL: begin
                            alu_ok = 1'b1;
                            alu_op = rv64de_pkg::ALU_SLL;
                        end
                        rv64de_pkg::F3_SR: begin
                            alu_ok = 1'b1;
                            alu_op = rv64de_pkg::ALU_SRL;
                        end
                        default: alu_ok = 1'b0;
                    endcase
                end else if (r_in.funct7 == rv64de_pkg::F7_ALT) begin
                    if (r_in.funct3 == rv64de_pkg::F3_ADD) begin
                        alu_ok = 1'b1;
                        alu_op = rv64de_pkg::ALU_SUB;
                    end else if (r_in.funct3 == rv64de_pkg::F3_SR) begin
                        alu_ok = 1'b1;
                        alu_op = rv64de_pkg::ALU_SRA;
                    end
                end
            end
            rv64de_pkg::OPC_OPIMM: begin
                // funct7 bit 0 is shamt bit 5, so only bits 6..1 select the shift
                unique case (r_in.funct3)
                    rv64de_pkg::F3_SLL: begin
                        if (r_in.funct7[6:1] == rv64de_pkg::F7_BASE[6:1]) begin
                            alu_ok = 1'b1;
                            alu_op = rv64de_pkg::ALU_SLL;
                        end
                    end
                    rv64de_pkg::F3_SR: begin
                        if (r_in.funct7[6:1] == rv64de_pkg::F7_BASE[6:1]) begin
                            alu_ok = 1'b1;
                            alu_op = rv64de_pkg::ALU_SRL;
                        end else if (r_in.funct7[6:1] == rv64de_pkg::F7_ALT[6:1]) begin
                            alu_ok = 1'b1;
                            alu_op = rv64de_pkg::ALU_SRA;
                        end
                    end
                    rv64de_pkg::F3_ADD: begin
                        alu_ok = 1'b1;
                        alu_op = rv64de_pkg::ALU_ADD;
                    end
                    rv64de_pkg::F3_SLT: begin
                        alu_ok = 1'b1;
                        alu_op = rv64de_pkg::ALU_SLT;
                    end
                    rv64de_pkg::F3_SLTU: begin
                        alu_ok = 1'b1;
                        alu_op = rv64de_pkg::ALU_SLTU;
                    end
                    rv64de_pkg::F3_XOR: begin
                        alu_ok = 1'b1;
                        alu_op = rv64de_pkg::ALU_XOR;
                    end
                    rv64de_pkg::F3_OR: begin
                        alu_ok = 1'b1;
                        alu_op = rv64de_pkg::ALU_OR;
                    end
                    default: begin
                        alu_ok = 1'b1;
                        alu_op = rv64de_pkg::ALU_AND;
                    end
                endcase
            end
            rv64de_pkg::OPC_OPIMMW: begin
                // word shift immediates need funct7 exactly base or alt
                alu_word = 1'b1;
                if (r_in.funct3 == rv64de_pkg::F3_ADD) begin
                    alu_ok = 1'b1;
                    alu_op = rv64de_pkg::ALU_ADD;
                end else if (r_in.funct3 == rv64de_pkg::F3_SLL
                             && r_in.funct7 == rv64de_pkg::F7_BASE) begin
                    alu_ok = 1'b1;
                    alu_op = rv64de_pkg::ALU_SLL;
                end else if (r_in.funct3 == rv64de_pkg::F3_SR
                             && r_in.funct7 == rv64de_pkg::F7_BASE) begin
                    alu_ok = 1'b1;
                    alu_op = rv64de_pkg::ALU_SRL;
                end else if (r_in.funct3 == rv64de_pkg::F3_SR
                             && r_in.funct7 == rv64de_pkg::F7_ALT) begin
                    alu_ok = 1'b1;
                    alu_op = rv64de_pkg::ALU_SRA;
                end
            end
            default: begin
                alu_ok = 1'b0;
            end
        endcase
    end

    // 32-bit results, sign-extended afterwards
    always_comb begin
        unique case (alu_op)
            rv64de_pkg::ALU_SUB: word_res = diff[31:0];
            rv64de_pkg::ALU_SLL: word_res = op_a[31:0] << sh32;
            rv64de_pkg::ALU_SRL: word_res = op_a[31:0] >> sh32;
            rv64de_pkg::ALU_SRA: word_res = 32'($signed(op_a[31:0]) >>> sh32);
            default:             word_res = sum[31:0];
        endcase
    end

    // 64-bit results
    always_comb begin
        if (alu_word) begin
            alu_res = sext32(word_res);
        end else begin
            unique case (alu_op)
                rv64de_pkg::ALU_ADD:  alu_res = sum;
                rv64de_pkg::ALU_SUB:  alu_res = diff;
                rv64de_pkg::ALU_SLL:  alu_res = op_a << sh64;
                rv64de_pkg::ALU_SLT:  alu_res = {63'd0, lt_s};
                rv64de_pkg::ALU_SLTU: alu_res = {63'd0, lt_u};
                rv64de_pkg::ALU_XOR:  alu_res = op_a ^ op_b;
                rv64de_pkg::ALU_SRL:  alu_res = op_a >> sh64;
                rv64de_pkg::ALU_SRA:  alu_res = 64'($signed(op_a) >>> sh64);
                rv64de_pkg::ALU_OR:   alu_res = op_a | op_b;
                default:              alu_res = op_a & op_b;
            endcase
        end
    end

    // branch condition
    always_comb begin
        case (r_in.funct3)
            rv64de_pkg::F3_BEQ:  taken = is_eq;
            rv64de_pkg::F3_BNE:  taken = !is_eq;
            rv64de_pkg::F3_BLT:  taken = lt_s;
            rv64de_pkg::F3_BGE:  taken = !lt_s;
            rv64de_pkg::F3_BLTU: taken = lt_u;
            rv64de_pkg::F3_BGEU: taken = !lt_u;
            default:             taken = 1'b0;
        endcase
    end

    // result beat assembly
    always_comb begin
        n_out = '0;
        unique case (r_in.opcode) inside
            rv64de_pkg::OPC_OP, rv64de_pkg::OPC_OPW,
            rv64de_pkg::OPC_OPIMM, rv64de_pkg::OPC_OPIMMW: begin
                if (alu_ok) begin
                    n_out.result_value = alu_res;
                    n_out.write_reg    = 1'b1;
                end
            end
            rv64de_pkg::OPC_LOAD: begin
                if (r_in.funct3 != rv64de_pkg::F3_LD_INVALID) begin
                    n_out.mem_bytes    = 4'd1 << r_in.funct3[1:0];
                    n_out.mem_signed   = r_in.funct3 < rv64de_pkg::F3_SLTU;
                    n_out.result_value = addr;
                    n_out.write_reg    = 1'b1;
                    n_out.load_to_reg  = 1'b1;
                    n_out.mem_read     = 1'b1;
                end
            end
            rv64de_pkg::OPC_STORE: begin
                if (!r_in.funct3[2]) begin
                    n_out.mem_bytes    = 4'd1 << r_in.funct3[1:0];
                    n_out.result_value = addr;
                    n_out.mem_write    = 1'b1;
                    n_out.store_data   = r_in.rs2_value;
                end
            end
            rv64de_pkg::OPC_BRANCH: begin
                if (r_in.funct3 != rv64de_pkg::F3_SLT && r_in.funct3 != rv64de_pkg::F3_SLTU) begin
                    n_out.result_value = diff;
                    if (taken) begin
                        n_out.redirect = 1'b1;
                        n_out.next_pc  = pc_imm;
                    end
                end
            end
            rv64de_pkg::OPC_JAL: begin
                n_out.result_value = r_in.pc + rv64de_pkg::INSN_BYTES;
                n_out.write_reg    = 1'b1;
                n_out.redirect     = 1'b1;
                n_out.next_pc      = pc_imm;
            end
            rv64de_pkg::OPC_JALR: begin
                if (r_in.funct3 == rv64de_pkg::F3_JALR) begin
                    n_out.result_value = r_in.pc + rv64de_pkg::INSN_BYTES;
                    n_out.write_reg    = 1'b1;
                    n_out.redirect     = 1'b1;
                    n_out.next_pc      = {addr[63:1], 1'b0};
                end
            end
            rv64de_pkg::OPC_LUI: begin
                n_out.result_value = r_in.immediate;
                n_out.write_reg    = 1'b1;
            end
            rv64de_pkg::OPC_AUIPC: begin
                n_out.result_value = pc_imm;
                n_out.write_reg    = 1'b1;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in <= i_in_beat;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_rv64i_decode_execute_unit.sv =====
// testbench for the rv64i decode and execute unit: directed and random instruction beats
// checked against an in-bench execute predictor; depends on rv64de_pkg and the unit itself
`timescale 1ns / 1ps

module tb_rv64i_decode_execute_unit;

    localparam int CYCLE_LIMIT = 200000;

    // operand corner values
    localparam logic [63:0] WORD_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] WORD_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] WORD_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // funct3 codes for loads and stores, plus encodings the unit must reject
    localparam logic [2:0] F3_LB        = 3'd0;
    localparam logic [2:0] F3_LD        = 3'd3;
    localparam logic [2:0] F3_LWU       = 3'd6;
    localparam logic [2:0] F3_SD        = 3'd3;
    localparam logic [2:0] F3_ST_BAD    = 3'd5;
    localparam logic [2:0] F3_BR_BAD    = 3'd2;
    localparam logic [2:0] F3_JALR_BAD  = 3'd1;
    localparam logic [6:0] OPC_UNUSED   = 7'h7F;

    // funct7 patterns around the shift-immediate decode
    localparam logic [6:0] F7_SHAMT5    = 7'h01;  // shamt bit 5 in funct7 bit 0
    localparam logic [6:0] F7_SRAI_HI   = 7'h21;  // srai with shamt bit 5 set
    localparam logic [6:0] F7_BAD_SHIFT = 7'h10;
    localparam logic [6:0] F7_JUNK      = 7'h5A;

    typedef enum logic {RX_READY, RX_RANDOM} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    rv64de_pkg::t_in_beat  i_in_beat = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    rv64de_pkg::t_out_beat o_out_beat;

    // expected result beats, oldest first
    rv64de_pkg::t_out_beat expected_results[$];
    rv64de_pkg::t_out_beat oldest;
    int        mismatch_count = 0;
    int        cycle_count = 0;

    // receiver control: a long hold takes priority over random stalls
    t_rx_mode  rx_mode = RX_RANDOM;
    int        hold_left = 0;
    int        stall_left = 0;

    rv64i_decode_execute_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // execute predictor
    // ---------------------------------------------------------------

    function automatic logic [63:0] sext_word(input logic [31:0] w);
        return {{32{w[31]}}, w};
    endfunction

    function automatic logic [63:0] alu_dword(input rv64de_pkg::t_alu_op op,
                                              input logic [63:0] a,
                                              input logic [63:0] b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic [5:0]         sh;
        sa = a;
        sb = b;
        sh = b[5:0];
        case (op)
            rv64de_pkg::ALU_ADD:  return a + b;
            rv64de_pkg::ALU_SUB:  return a - b;
            rv64de_pkg::ALU_SLL:  return a << sh;
            rv64de_pkg::ALU_SLT:  return {63'd0, sa < sb};
            rv64de_pkg::ALU_SLTU: return {63'd0, a < b};
            rv64de_pkg::ALU_XOR:  return a ^ b;
            rv64de_pkg::ALU_SRL:  return a >> sh;
            rv64de_pkg::ALU_SRA:  return sa >>> sh;
            rv64de_pkg::ALU_OR:   return a | b;
            default:              return a & b;
        endcase
    endfunction

    // word ops: 32-bit result, sign-extended, shift amount from 5 bits
    function automatic logic [63:0] alu_word(input rv64de_pkg::t_alu_op op,
                                             input logic [63:0] a,
                                             input logic [63:0] b);
        logic [31:0]        lo;
        logic signed [31:0] slo;
        logic [4:0]         sh;
        lo  = a[31:0];
        slo = a[31:0];
        sh  = b[4:0];
        case (op)
            rv64de_pkg::ALU_ADD: return sext_word(lo + b[31:0]);
            rv64de_pkg::ALU_SUB: return sext_word(lo - b[31:0]);
            rv64de_pkg::ALU_SLL: return sext_word(lo << sh);
            rv64de_pkg::ALU_SRL: return sext_word(lo >> sh);
            default:             return sext_word(slo >>> sh);
        endcase
    endfunction

    // register-register decode; word form only has add, sub and the shifts
    function automatic logic decode_reg_op(input logic [2:0] f3, input logic [6:0] f7,
                                           input logic word,
                                           output rv64de_pkg::t_alu_op op);
        op = rv64de_pkg::ALU_ADD;
        if (f7 == rv64de_pkg::F7_BASE) begin
            case (f3)
                rv64de_pkg::F3_ADD:  begin op = rv64de_pkg::ALU_ADD;  return 1'b1; end
                rv64de_pkg::F3_SLL:  begin op = rv64de_pkg::ALU_SLL;  return 1'b1; end
                rv64de_pkg::F3_SLT:  begin op = rv64de_pkg::ALU_SLT;  return !word; end
                rv64de_pkg::F3_SLTU: begin op = rv64de_pkg::ALU_SLTU; return !word; end
                rv64de_pkg::F3_XOR:  begin op = rv64de_pkg::ALU_XOR;  return !word; end
                rv64de_pkg::F3_SR:   begin op = rv64de_pkg::ALU_SRL;  return 1'b1; end
                rv64de_pkg::F3_OR:   begin op = rv64de_pkg::ALU_OR;   return !word; end
                default:             begin op = rv64de_pkg::ALU_AND;  return !word; end
            endcase
        end
        if (f7 == rv64de_pkg::F7_ALT && f3 == rv64de_pkg::F3_ADD) begin
            op = rv64de_pkg::ALU_SUB;
            return 1'b1;
        end
        if (f7 == rv64de_pkg::F7_ALT && f3 == rv64de_pkg::F3_SR) begin
            op = rv64de_pkg::ALU_SRA;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic rv64de_pkg::t_out_beat execute_instr(input rv64de_pkg::t_in_beat ib);
        rv64de_pkg::t_out_beat r;
        rv64de_pkg::t_alu_op   op;
        logic               known;
        logic               taken;
        logic [63:0]        a;
        logic [63:0]        b;
        logic [63:0]        imm;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        r     = '0;
        op    = rv64de_pkg::ALU_ADD;
        known = 1'b0;
        taken = 1'b0;
        a     = ib.rs1_value;
        b     = ib.rs2_value;
        imm   = ib.immediate;
        sa    = a;
        sb    = b;
        case (ib.opcode)
            rv64de_pkg::OPC_OP: begin
                if (decode_reg_op(ib.funct3, ib.funct7, 1'b0, op)) begin
                    r.result_value = alu_dword(op, a, b);
                    r.write_reg    = 1'b1;
                end
            end
            rv64de_pkg::OPC_OPW: begin
                if (decode_reg_op(ib.funct3, ib.funct7, 1'b1, op)) begin
                    r.result_value = alu_word(op, a, b);
                    r.write_reg    = 1'b1;
                end
            end
            rv64de_pkg::OPC_OPIMM: begin
                // funct7 bit 0 is shamt bit 5, so shifts only look at bits 6..1
                known = 1'b1;
                case (ib.funct3)
                    rv64de_pkg::F3_ADD:  op = rv64de_pkg::ALU_ADD;
                    rv64de_pkg::F3_SLT:  op = rv64de_pkg::ALU_SLT;
                    rv64de_pkg::F3_SLTU: op = rv64de_pkg::ALU_SLTU;
                    rv64de_pkg::F3_XOR:  op = rv64de_pkg::ALU_XOR;
                    rv64de_pkg::F3_OR:   op = rv64de_pkg::ALU_OR;
                    rv64de_pkg::F3_AND:  op = rv64de_pkg::ALU_AND;
                    rv64de_pkg::F3_SLL: begin
                        op    = rv64de_pkg::ALU_SLL;
                        known = (ib.funct7[6:1] == rv64de_pkg::F7_BASE[6:1]);
                    end
                    default: begin
                        if (ib.funct7[6:1] == rv64de_pkg::F7_BASE[6:1])
                            op = rv64de_pkg::ALU_SRL;
                        else if (ib.funct7[6:1] == rv64de_pkg::F7_ALT[6:1])
                            op = rv64de_pkg::ALU_SRA;
                        else
                            known = 1'b0;
                    end
                endcase
                if (known) begin
                    r.result_value = alu_dword(op, a, imm);
                    r.write_reg    = 1'b1;
                end
            end
            rv64de_pkg::OPC_OPIMMW: begin
                // word shift immediates need an exact funct7
                known = 1'b1;
                if (ib.funct3 == rv64de_pkg::F3_ADD)
                    op = rv64de_pkg::ALU_ADD;
                else if (ib.funct3 == rv64de_pkg::F3_SLL && ib.funct7 == rv64de_pkg::F7_BASE)
                    op = rv64de_pkg::ALU_SLL;
                else if (ib.funct3 == rv64de_pkg::F3_SR && ib.funct7 == rv64de_pkg::F7_BASE)
                    op = rv64de_pkg::ALU_SRL;
                else if (ib.funct3 == rv64de_pkg::F3_SR && ib.funct7 == rv64de_pkg::F7_ALT)
                    op = rv64de_pkg::ALU_SRA;
                else
                    known = 1'b0;
                if (known) begin
                    r.result_value = alu_word(op, a, imm);
                    r.write_reg    = 1'b1;
                end
            end
            rv64de_pkg::OPC_LOAD: begin
                if (ib.funct3 != rv64de_pkg::F3_LD_INVALID) begin
                    r.mem_bytes    = 4'd1 << ib.funct3[1:0];
                    r.mem_signed   = !ib.funct3[2] && ib.funct3[1:0] != F3_LD[1:0];
                    r.result_value = a + imm;
                    r.write_reg    = 1'b1;
                    r.load_to_reg  = 1'b1;
                    r.mem_read     = 1'b1;
                end
            end
            rv64de_pkg::OPC_STORE: begin
                if (!ib.funct3[2]) begin
                    r.mem_bytes    = 4'd1 << ib.funct3[1:0];
                    r.result_value = a + imm;
                    r.mem_write    = 1'b1;
                    r.store_data   = b;
                end
            end
            rv64de_pkg::OPC_BRANCH: begin
                known = 1'b1;
                case (ib.funct3)
                    rv64de_pkg::F3_BEQ:  taken = (a == b);
                    rv64de_pkg::F3_BNE:  taken = (a != b);
                    rv64de_pkg::F3_BLT:  taken = (sa < sb);
                    rv64de_pkg::F3_BGE:  taken = (sa >= sb);
                    rv64de_pkg::F3_BLTU: taken = (a < b);
                    rv64de_pkg::F3_BGEU: taken = (a >= b);
                    default:             known = 1'b0;
                endcase
                if (known) begin
                    r.result_value = a - b;
                    r.redirect     = taken;
                    if (taken)
                        r.next_pc = ib.pc + imm;
                end
            end
            rv64de_pkg::OPC_JAL: begin
                r.result_value = ib.pc + rv64de_pkg::INSN_BYTES;
                r.write_reg    = 1'b1;
                r.redirect     = 1'b1;
                r.next_pc      = ib.pc + imm;
            end
            rv64de_pkg::OPC_JALR: begin
                if (ib.funct3 == rv64de_pkg::F3_JALR) begin
                    r.result_value = ib.pc + rv64de_pkg::INSN_BYTES;
                    r.write_reg    = 1'b1;
                    r.redirect     = 1'b1;
                    r.next_pc      = (a + imm) & ~64'd1;
                end
            end
            rv64de_pkg::OPC_LUI: begin
                r.result_value = imm;
                r.write_reg    = 1'b1;
            end
            rv64de_pkg::OPC_AUIPC: begin
                r.result_value = ib.pc + imm;
                r.write_reg    = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // random helpers
    // ---------------------------------------------------------------

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WORD_ONES;
            2:       return WORD_MIN;
            3:       return WORD_MAX;
            4:       return {32'd0, $urandom_range(0, 70)};
            5:       return {32'hFFFF_FFFF, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly short idle runs, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int send_gap();
        if ($urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    // mostly well-formed encodings with random operands, some pure noise
    function automatic rv64de_pkg::t_in_beat random_instr();
        rv64de_pkg::t_in_beat ib;
        logic [11:0] s12;
        ib.rs1_value = rand_word();
        ib.rs2_value = rand_word();
        if ($urandom_range(0, 3) == 0)
            ib.rs2_value = ib.rs1_value;     // equal operands for branch compares
        s12 = 12'($urandom);
        if ($urandom_range(0, 3) == 0)
            ib.immediate = rand_word();
        else
            ib.immediate = {{52{s12[11]}}, s12};
        ib.pc     = {$urandom, $urandom};
        ib.funct3 = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 19) < 17) begin
            case ($urandom_range(0, 10))
                0:       ib.opcode = rv64de_pkg::OPC_LOAD;
                1:       ib.opcode = rv64de_pkg::OPC_OPIMM;
                2:       ib.opcode = rv64de_pkg::OPC_AUIPC;
                3:       ib.opcode = rv64de_pkg::OPC_OPIMMW;
                4:       ib.opcode = rv64de_pkg::OPC_STORE;
                5:       ib.opcode = rv64de_pkg::OPC_OP;
                6:       ib.opcode = rv64de_pkg::OPC_LUI;
                7:       ib.opcode = rv64de_pkg::OPC_OPW;
                8:       ib.opcode = rv64de_pkg::OPC_BRANCH;
                9:       ib.opcode = rv64de_pkg::OPC_JALR;
                default: ib.opcode = rv64de_pkg::OPC_JAL;
            endcase
            case ($urandom_range(0, 9)) inside
                [0:4]:   ib.funct7 = rv64de_pkg::F7_BASE;
                [5:7]:   ib.funct7 = rv64de_pkg::F7_ALT;
                default: ib.funct7 = 7'($urandom_range(0, 127));
            endcase
            if (ib.opcode == rv64de_pkg::OPC_OPIMM)
                ib.funct7[0] = 1'($urandom_range(0, 1));
            if (ib.opcode == rv64de_pkg::OPC_JALR && $urandom_range(0, 3) != 0)
                ib.funct3 = rv64de_pkg::F3_JALR;
            if (ib.opcode == rv64de_pkg::OPC_STORE && $urandom_range(0, 3) != 0)
                ib.funct3[2] = 1'b0;
        end else begin
            ib.opcode = 7'($urandom_range(0, 127));
            ib.funct7 = 7'($urandom_range(0, 127));
        end
        return ib;
    endfunction

    // ---------------------------------------------------------------
    // sender: holds the beat until it is taken, then drops valid for the requested gap;
    // with no gap, valid stays high and the caller offers the next beat
    // in the same time step
    // ---------------------------------------------------------------

    task automatic offer_instr(input rv64de_pkg::t_in_beat beat, input int gap);
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        expected_results.push_back(execute_instr(beat));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue(input logic [6:0] opc, input logic [2:0] f3, input logic [6:0] f7,
                         input logic [63:0] a, input logic [63:0] b,
                         input logic [63:0] imm, input logic [63:0] pc);
        rv64de_pkg::t_in_beat ib;
        ib.opcode    = opc;
        ib.funct3    = f3;
        ib.funct7    = f7;
        ib.rs1_value = a;
        ib.rs2_value = b;
        ib.immediate = imm;
        ib.pc        = pc;
        offer_instr(ib, send_gap());
    endtask

    // sender goes quiet until every expected beat is back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_alu_extremes();
        issue(rv64de_pkg::OPC_OP, rv64de_pkg::F3_ADD, rv64de_pkg::F7_BASE, WORD_ONES, 64'd1,
              64'd0, rand_word());
        issue(rv64de_pkg::OPC_OP, rv64de_pkg::F3_ADD, rv64de_pkg::F7_ALT, 64'd0, 64'd1,
              64'd0, rand_word());
        // sra with all-ones shift operand: only the low 6 bits count
        issue(rv64de_pkg::OPC_OP, rv64de_pkg::F3_SR, rv64de_pkg::F7_ALT, WORD_MIN, WORD_ONES,
              64'd0, rand_word());
        issue(rv64de_pkg::OPC_OP, rv64de_pkg::F3_SLT, rv64de_pkg::F7_BASE, WORD_MIN, WORD_MAX,
              64'd0, rand_word());
        // sltiu against -1, junk funct7 must be ignored
        issue(rv64de_pkg::OPC_OPIMM, rv64de_pkg::F3_SLTU, F7_JUNK, WORD_MAX, 64'd0, WORD_ONES,
              rand_word());
    endtask

    task automatic test_word_ops();
        issue(rv64de_pkg::OPC_OPW, rv64de_pkg::F3_ADD, rv64de_pkg::F7_BASE,
              64'hDEAD_BEEF_7FFF_FFFF, 64'd1, 64'd0, rand_word());
        issue(rv64de_pkg::OPC_OPW, rv64de_pkg::F3_SR, rv64de_pkg::F7_ALT,
              64'h1234_5678_8000_0000, 64'hFF, 64'd0, rand_word());
        issue(rv64de_pkg::OPC_OPIMMW, rv64de_pkg::F3_SR, rv64de_pkg::F7_BASE, WORD_ONES, 64'd0,
              64'd1, rand_word());
    endtask

    task automatic test_shift_immediates();
        issue(rv64de_pkg::OPC_OPIMM, rv64de_pkg::F3_SLL, F7_SHAMT5, 64'd1, 64'd0, 64'd40,
              rand_word());
        issue(rv64de_pkg::OPC_OPIMM, rv64de_pkg::F3_SR, F7_SRAI_HI, WORD_MIN, 64'd0, 64'd63,
              rand_word());
        issue(rv64de_pkg::OPC_OPIMM, rv64de_pkg::F3_SR, F7_BAD_SHIFT, WORD_ONES, 64'd0, 64'd3,
              rand_word());
        // word shifts have no shamt bit 5, so an odd funct7 is rejected
        issue(rv64de_pkg::OPC_OPIMMW, rv64de_pkg::F3_SLL, F7_SHAMT5, WORD_ONES, 64'd0, 64'd3,
              rand_word());
        issue(rv64de_pkg::OPC_OPIMMW, rv64de_pkg::F3_SR, rv64de_pkg::F7_ALT,
              64'h0000_0000_8000_0000, 64'd0, 64'd4, rand_word());
    endtask

    task automatic test_memory_access();
        issue(rv64de_pkg::OPC_LOAD, F3_LB, F7_JUNK, 64'h1000, WORD_ONES, WORD_ONES,
              rand_word());
        issue(rv64de_pkg::OPC_LOAD, F3_LD, rv64de_pkg::F7_BASE, WORD_ONES, 64'd0, 64'd1,
              rand_word());
        issue(rv64de_pkg::OPC_LOAD, F3_LWU, rv64de_pkg::F7_BASE, WORD_MAX, 64'd0, 64'd8,
              rand_word());
        issue(rv64de_pkg::OPC_LOAD, rv64de_pkg::F3_LD_INVALID, rv64de_pkg::F7_BASE, WORD_MAX,
              64'd0, 64'd8, rand_word());
        issue(rv64de_pkg::OPC_STORE, F3_SD, rv64de_pkg::F7_BASE, 64'h2000, WORD_MIN,
              64'hFFFF_FFFF_FFFF_FFF8, rand_word());
        issue(rv64de_pkg::OPC_STORE, F3_ST_BAD, rv64de_pkg::F7_BASE, 64'h2000, WORD_ONES,
              64'd4, rand_word());
    endtask

    task automatic test_control_flow();
        issue(rv64de_pkg::OPC_BRANCH, rv64de_pkg::F3_BEQ, rv64de_pkg::F7_BASE, WORD_MIN,
              WORD_MIN, 64'd16, 64'h8000);
        issue(rv64de_pkg::OPC_BRANCH, rv64de_pkg::F3_BLT, rv64de_pkg::F7_BASE, WORD_MAX,
              WORD_MIN, 64'd16, 64'h8000);
        issue(rv64de_pkg::OPC_BRANCH, F3_BR_BAD, rv64de_pkg::F7_BASE, 64'd1, 64'd2, 64'd16,
              64'h8000);
        issue(rv64de_pkg::OPC_JAL, rv64de_pkg::F3_ADD, F7_JUNK, 64'd0, 64'd0,
              64'hFFFF_FFFF_FFFF_FFF8, 64'h4);
        // jalr target lands odd and must lose bit 0
        issue(rv64de_pkg::OPC_JALR, rv64de_pkg::F3_JALR, rv64de_pkg::F7_BASE, 64'h1001, 64'd0,
              64'd4, WORD_ONES);
        issue(rv64de_pkg::OPC_JALR, F3_JALR_BAD, rv64de_pkg::F7_BASE, 64'h1001, 64'd0, 64'd4,
              64'h100);
        issue(rv64de_pkg::OPC_LUI, rv64de_pkg::F3_AND, F7_JUNK, WORD_ONES, WORD_ONES, WORD_MIN,
              rand_word());
        issue(rv64de_pkg::OPC_AUIPC, rv64de_pkg::F3_ADD, rv64de_pkg::F7_BASE, 64'd0, 64'd0,
              64'd8, WORD_ONES);
    endtask

    task automatic test_unknown_encodings();
        issue(OPC_UNUSED, rv64de_pkg::F3_AND, F7_JUNK, WORD_ONES, WORD_ONES, WORD_ONES,
              WORD_ONES);
        issue(rv64de_pkg::OPC_OP, rv64de_pkg::F3_ADD, F7_SHAMT5, 64'd5, 64'd7, 64'd0,
              rand_word());
    endtask

    // back-to-back beats with a ready receiver
    task automatic test_full_rate(input int count);
        rx_mode <= RX_READY;
        repeat (count)
            offer_instr(random_instr(), 0);
        wait_results_drained();
    endtask

    // receiver holds off long enough that both stages fill and the input stalls
    task automatic test_backpressure(input int count);
        rx_mode   <= RX_READY;
        hold_left <= 150;
        repeat (count)
            offer_instr(random_instr(), 0);
        wait_results_drained();
    endtask

    task automatic test_random_stream(input int count);
        rx_mode <= RX_RANDOM;
        repeat (count)
            offer_instr(random_instr(), send_gap());
    endtask

    // ---------------------------------------------------------------
    // receiver stall generator
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (rx_mode == RX_RANDOM && stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (rx_mode == RX_RANDOM && $urandom_range(0, 99) < 30)
                stall_left <= idle_len();
        end
    end

    // ---------------------------------------------------------------
    // result checker: every accepted result beat against the oldest expectation
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result beat expected none, actual %h", $time, o_out_beat);
                mismatch_count++;
            end else begin
                oldest = expected_results.pop_front();
                check_field("result_value", oldest.result_value, o_out_beat.result_value);
                check_field("write_reg", 64'(oldest.write_reg), 64'(o_out_beat.write_reg));
                check_field("load_to_reg", 64'(oldest.load_to_reg),
                            64'(o_out_beat.load_to_reg));
                check_field("mem_read", 64'(oldest.mem_read), 64'(o_out_beat.mem_read));
                check_field("mem_write", 64'(oldest.mem_write), 64'(o_out_beat.mem_write));
                check_field("mem_bytes", 64'(oldest.mem_bytes), 64'(o_out_beat.mem_bytes));
                check_field("mem_signed", 64'(oldest.mem_signed),
                            64'(o_out_beat.mem_signed));
                check_field("store_data", oldest.store_data, o_out_beat.store_data);
                check_field("redirect", 64'(oldest.redirect), 64'(o_out_beat.redirect));
                check_field("next_pc", oldest.next_pc, o_out_beat.next_pc);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("rv64i_decode_execute_unit: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_alu_extremes();
        test_word_ops();
        test_shift_immediates();
        test_memory_access();
        test_control_flow();
        test_unknown_encodings();
        wait_results_drained();

        test_full_rate(40);
        test_backpressure(24);
        test_random_stream(320);

        // let the pipeline empty, then wait on for stray beats
        wait_results_drained();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("rv64i_decode_execute_unit: match");
        else
            $display("rv64i_decode_execute_unit: mismatch");
        $finish;
    end

endmodule
